// ----- rtl/qrrts_pkg.sv -----
`timescale 1ns / 1ps

package qrrts_pkg;

    localparam int MAX_THREADS_DEF  = 16;
    localparam int QUANTUM_BITS_DEF = 8;
    localparam int QRESET_DEF       = 10;

    localparam int ACTION_W = 3;
    localparam int ID_W     = 4;
    localparam int CFG_W    = 8;

    localparam logic [ACTION_W-1:0] ACT_TICK     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CREATE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CONTINUE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_KILL     = 3'd4;

    // controller to datapath, at most one phase per cycle
    typedef struct packed {
        logic latch;
        logic dec;
        logic exe;
        logic cut;
        logic pop;
        logic pop_id;
        logic pop_chk;
        logic done;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op_bad;
        logic tick_idle;
        logic need_cut;
        logic need_pop;
        logic ring_empty;
        logic pop_hit;
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/qrrts_if.sv -----
`timescale 1ns / 1ps

interface qrrts_evt_if;
    logic                              valid;
    logic                              ready;
    logic [qrrts_pkg::ACTION_W-1:0]    action;
    logic [qrrts_pkg::ID_W-1:0]        thread_id;
    logic                              responsive;

    modport source (output valid, output action, output thread_id, output responsive,
                    input ready);
    modport sink (input valid, input action, input thread_id, input responsive,
                  output ready);
endinterface

interface qrrts_res_if;
    logic                              valid;
    logic                              ready;
    logic [qrrts_pkg::ID_W-1:0]        running_id;
    logic                              idle_running;
    logic                              switched;
    logic                              accepted;

    modport source (output valid, output running_id, output idle_running, output switched,
                    output accepted, input ready);
    modport sink (input valid, input running_id, input idle_running, input switched,
                  input accepted, output ready);
endinterface

// ----- rtl/qrrts_ctrl.sv -----
`timescale 1ns / 1ps

module qrrts_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  qrrts_pkg::sts_t sts,
    output qrrts_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DEC     = 3'd1;
    localparam logic [2:0] S_EXE     = 3'd2;
    localparam logic [2:0] S_CUT     = 3'd3;
    localparam logic [2:0] S_POP     = 3'd4;
    localparam logic [2:0] S_POP_ID  = 3'd5;
    localparam logic [2:0] S_POP_CHK = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
                if (in_valid)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.dec = 1'b1;
                if (sts.op_bad)
                begin
                    state_next = S_DONE;
                end
                else if (sts.tick_idle)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_EXE;
                end
            end
            S_EXE:
            begin
                cmd.exe = 1'b1;
                if (sts.need_cut)
                begin
                    state_next = S_CUT;
                end
                else if (sts.need_pop)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CUT:
            begin
                cmd.cut    = 1'b1;
                state_next = S_DONE;
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = sts.ring_empty ? S_DONE : S_POP_ID;
            end
            S_POP_ID:
            begin
                cmd.pop_id = 1'b1;
                state_next = S_POP_CHK;
            end
            S_POP_CHK:
            begin
                cmd.pop_chk = 1'b1;
                state_next  = sts.pop_hit ? S_DONE : S_POP;
            end
            S_DONE:
            begin
                cmd.done = 1'b1;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_cut_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CUT |=> state_reg == S_DONE)
        else $error("cut phase not followed by result");

    a_pop_id_then_chk: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP_ID |=> state_reg == S_POP_CHK)
        else $error("pop lookup broken");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && !sts.out_free |=> state_reg == S_DONE)
        else $error("result dropped while output busy");

endmodule

// ----- rtl/qrrts_dpath.sv -----
`timescale 1ns / 1ps

module qrrts_dpath
#(
    parameter int MAX_THREADS  = qrrts_pkg::MAX_THREADS_DEF,
    parameter int QUANTUM_BITS = qrrts_pkg::QUANTUM_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  qrrts_pkg::cmd_t                 cmd,
    output qrrts_pkg::sts_t                 sts,
    input  logic [QUANTUM_BITS-1:0]         qreset,
    input  logic [qrrts_pkg::ACTION_W-1:0]  action,
    input  logic [qrrts_pkg::ID_W-1:0]      thread_id,
    input  logic                            responsive,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [qrrts_pkg::ID_W-1:0]      running_id,
    output logic                            idle_running,
    output logic                            switched,
    output logic                            accepted
);

    localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam int QB = QUANTUM_BITS;

    localparam logic [qrrts_pkg::ACTION_W-1:0] ACT_TICK     = qrrts_pkg::ACT_TICK;
    localparam logic [qrrts_pkg::ACTION_W-1:0] ACT_CREATE   = qrrts_pkg::ACT_CREATE;
    localparam logic [qrrts_pkg::ACTION_W-1:0] ACT_STOP     = qrrts_pkg::ACT_STOP;
    localparam logic [qrrts_pkg::ACTION_W-1:0] ACT_CONTINUE = qrrts_pkg::ACT_CONTINUE;
    localparam logic [qrrts_pkg::ACTION_W-1:0] ACT_KILL     = qrrts_pkg::ACT_KILL;

    localparam logic [2:0] ST_UNUSED     = 3'd0;
    localparam logic [2:0] ST_READY      = 3'd1;
    localparam logic [2:0] ST_RUNNING    = 3'd2;
    localparam logic [2:0] ST_SUSPENDED  = 3'd3;
    localparam logic [2:0] ST_TERMINATED = 3'd4;

    typedef struct packed {
        logic [2:0] status;
        logic       resp;
    } tent_t;

    // latched item
    logic [qrrts_pkg::ACTION_W-1:0] act_reg;
    logic [qrrts_pkg::ID_W-1:0]     tid_reg;
    logic                           resp_reg;
    logic                           prev_idle_reg;
    logic [TW-1:0]                  prev_id_reg;
    logic                           acc_reg;
    logic                           acc_next;

    logic [TW-1:0]                  cur_reg;
    logic [TW-1:0]                  cur_next;
    logic                           cur_idle_reg;
    logic                           cur_idle_next;
    logic [TW-1:0]                  head_reg;
    logic [TW-1:0]                  head_next;
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  count_next;
    logic [MAX_THREADS-1:0]         queued_reg;
    logic [MAX_THREADS-1:0]         queued_next;

    // thread table: status and responsive mark, quantum, each with valid flops
    tent_t                          smem [MAX_THREADS];
    logic [MAX_THREADS-1:0]         svalid_reg;
    tent_t                          s_rd_reg;
    logic                           s_rv_reg;
    logic [QB-1:0]                  qmem [MAX_THREADS];
    logic [MAX_THREADS-1:0]         qvalid_reg;
    logic [QB-1:0]                  q_rd_reg;
    logic                           q_rv_reg;
    logic [TW-1:0]                  ring_mem [MAX_THREADS];
    logic [TW-1:0]                  ring_rd_reg;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [qrrts_pkg::ID_W-1:0]     out_id_reg;
    logic                           out_idle_reg;
    logic                           out_sw_reg;
    logic                           out_acc_reg;

    logic                           tid_ok;
    logic [TW-1:0]                  tid_idx;
    logic [TW-1:0]                  tgt;
    logic [2:0]                     st_t;
    logic                           resp_t;
    logic [QB-1:0]                  q_t;
    logic                           live;
    logic                           is_cur;
    logic                           pop_hit;

    logic                           s_we;
    logic [TW-1:0]                  s_wa;
    tent_t                          s_wd;
    logic [TW-1:0]                  s_ra;
    logic                           q_we;
    logic [TW-1:0]                  q_wa;
    logic [QB-1:0]                  q_wd;
    logic                           push_t;
    logic                           push_h;
    logic                           push_ok;
    logic                           need_pop;
    logic                           need_cut;
    logic                           acc_set;
    logic [CW:0]                    tail_sum;
    logic [TW-1:0]                  tail_pos;
    logic [TW-1:0]                  head_dec;
    logic [TW-1:0]                  head_inc;

    assign tid_ok  = {28'd0, tid_reg} < 32'(MAX_THREADS);
    assign tid_idx = TW'(tid_reg);
    assign tgt     = (act_reg == ACT_TICK) ? cur_reg : tid_idx;
    assign st_t    = s_rv_reg ? s_rd_reg.status : ST_UNUSED;
    assign resp_t  = s_rv_reg & s_rd_reg.resp;
    assign q_t     = q_rv_reg ? q_rd_reg : '0;
    assign live    = (st_t != ST_UNUSED) && (st_t != ST_TERMINATED);
    assign is_cur  = !cur_idle_reg && (cur_reg == tid_idx);
    assign pop_hit = s_rv_reg && (s_rd_reg.status == ST_READY);
    assign push_ok = !queued_reg[tgt] && (count_reg < CW'(MAX_THREADS));

    assign tail_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign tail_pos = (tail_sum >= (CW+1)'(MAX_THREADS))
                    ? TW'(tail_sum - (CW+1)'(MAX_THREADS)) : TW'(tail_sum);
    assign head_dec = (head_reg == '0) ? TW'(MAX_THREADS - 1) : head_reg - TW'(1);
    assign head_inc = (head_reg == TW'(MAX_THREADS - 1)) ? '0 : head_reg + TW'(1);

    // item execution
    always_comb
    begin
        s_we     = 1'b0;
        s_wd     = '{status: ST_READY, resp: resp_t};
        q_we     = 1'b0;
        q_wd     = qreset;
        push_t   = 1'b0;
        push_h   = 1'b0;
        need_pop = 1'b0;
        need_cut = 1'b0;
        acc_set  = 1'b0;
        case (act_reg)
            ACT_TICK:
            begin
                q_we = 1'b1;
                if (q_t <= QB'(1))
                begin
                    s_we     = 1'b1;
                    push_t   = 1'b1;
                    need_pop = 1'b1;
                end
                else
                begin
                    q_wd = q_t - QB'(1);
                end
            end
            ACT_CREATE:
            begin
                if (!live)
                begin
                    acc_set = 1'b1;
                    s_we    = 1'b1;
                    s_wd    = '{status: ST_READY, resp: resp_reg};
                    q_we    = 1'b1;
                    push_t  = 1'b1;
                end
            end
            ACT_STOP:
            begin
                if (live)
                begin
                    acc_set  = 1'b1;
                    s_we     = 1'b1;
                    s_wd     = '{status: ST_SUSPENDED, resp: resp_t};
                    q_we     = 1'b1;
                    need_pop = is_cur;
                end
            end
            ACT_CONTINUE:
            begin
                if (live)
                begin
                    acc_set = 1'b1;
                    q_we    = 1'b1;
                    if (!is_cur)
                    begin
                        s_we = 1'b1;
                        if (resp_t)
                        begin
                            push_h   = 1'b1;
                            need_cut = !cur_idle_reg;
                        end
                        else
                        begin
                            push_t = 1'b1;
                        end
                    end
                end
            end
            ACT_KILL:
            begin
                if (live)
                begin
                    acc_set  = 1'b1;
                    s_we     = 1'b1;
                    s_wd     = '{status: ST_TERMINATED, resp: resp_t};
                    need_pop = is_cur;
                end
            end
            default:
            begin
                acc_set = 1'b0;
            end
        endcase

        s_we = s_we && cmd.exe;
        q_we = q_we && cmd.exe;
        if (cmd.pop_chk)
        begin
            s_we = pop_hit;
            s_wd = '{status: ST_RUNNING, resp: s_rd_reg.resp};
        end
        if (cmd.cut)
        begin
            q_we = 1'b1;
            q_wd = QB'(1);
        end
    end

    assign s_wa = cmd.pop_chk ? ring_rd_reg : tgt;
    assign s_ra = cmd.pop_id ? ring_rd_reg : tgt;
    assign q_wa = cmd.cut ? cur_reg : tgt;

    // control state next values
    always_comb
    begin
        acc_next      = acc_reg;
        cur_next      = cur_reg;
        cur_idle_next = cur_idle_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        queued_next   = queued_reg;
        if (cmd.latch)
        begin
            acc_next = (action == ACT_TICK);
        end
        if (cmd.exe)
        begin
            if (acc_set)
            begin
                acc_next = 1'b1;
            end
            if ((push_t || push_h) && push_ok)
            begin
                count_next       = count_reg + CW'(1);
                queued_next[tgt] = 1'b1;
                if (push_h)
                begin
                    head_next = head_dec;
                end
            end
        end
        if (cmd.pop)
        begin
            if (count_reg == '0)
            begin
                cur_idle_next = 1'b1;
            end
            else
            begin
                head_next  = head_inc;
                count_next = count_reg - CW'(1);
            end
        end
        if (cmd.pop_id)
        begin
            queued_next[ring_rd_reg] = 1'b0;
        end
        if (cmd.pop_chk && pop_hit)
        begin
            cur_next      = ring_rd_reg;
            cur_idle_next = 1'b0;
        end
    end

    assign out_valid_next = (cmd.done && sts.out_free) ? 1'b1
                          : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 1'b0;
            cur_reg       <= '0;
            cur_idle_reg  <= 1'b1;
            head_reg      <= '0;
            count_reg     <= '0;
            queued_reg    <= '0;
            svalid_reg    <= '0;
            qvalid_reg    <= '0;
            s_rv_reg      <= 1'b0;
            q_rv_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cur_reg       <= cur_next;
            cur_idle_reg  <= cur_idle_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            queued_reg    <= queued_next;
            out_valid_reg <= out_valid_next;
            if (s_we)
            begin
                svalid_reg[s_wa] <= 1'b1;
            end
            if (q_we)
            begin
                qvalid_reg[q_wa] <= 1'b1;
            end
            if (cmd.dec || cmd.pop_id)
            begin
                s_rv_reg <= svalid_reg[s_ra];
            end
            if (cmd.dec)
            begin
                q_rv_reg <= qvalid_reg[tgt];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            smem[s_wa] <= s_wd;
        end
        if (cmd.dec || cmd.pop_id)
        begin
            s_rd_reg <= smem[s_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            qmem[q_wa] <= q_wd;
        end
        if (cmd.dec)
        begin
            q_rd_reg <= qmem[tgt];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exe && push_ok && push_t)
        begin
            ring_mem[tail_pos] <= tgt;
        end
        else if (cmd.exe && push_ok && push_h)
        begin
            ring_mem[head_dec] <= tgt;
        end
        if (cmd.pop && (count_reg != '0))
        begin
            ring_rd_reg <= ring_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg       <= action;
            tid_reg       <= thread_id;
            resp_reg      <= responsive;
            prev_idle_reg <= cur_idle_reg;
            prev_id_reg   <= cur_reg;
        end
        if (cmd.done && sts.out_free)
        begin
            out_id_reg   <= cur_idle_reg ? '0 : qrrts_pkg::ID_W'(cur_reg);
            out_idle_reg <= cur_idle_reg;
            out_sw_reg   <= (cur_idle_reg != prev_idle_reg)
                         || (!cur_idle_reg && (cur_reg != prev_id_reg));
            out_acc_reg  <= acc_reg;
        end
    end

    assign sts.op_bad     = (act_reg > ACT_KILL) || ((act_reg != ACT_TICK) && !tid_ok);
    assign sts.tick_idle  = (act_reg == ACT_TICK) && cur_idle_reg;
    assign sts.need_cut   = need_cut;
    assign sts.need_pop   = need_pop;
    assign sts.ring_empty = (count_reg == '0);
    assign sts.pop_hit    = pop_hit;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign running_id   = out_id_reg;
    assign idle_running = out_idle_reg;
    assign switched     = out_sw_reg;
    assign accepted     = out_acc_reg;

    // the popped entry keeps its mark until the lookup cycle
    a_queued_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(queued_reg) == int'(count_reg) + int'(cmd.pop_id))
        else $error("queued marks disagree with ring count");

    a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(head_reg) < 32'(MAX_THREADS)) && (32'(count_reg) <= 32'(MAX_THREADS)))
        else $error("ring pointer out of range");

    a_pop_hit_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_chk && pop_hit |=> !cur_idle_reg && cur_reg == $past(ring_rd_reg))
        else $error("popped ready thread not running");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exe && (push_t || push_h) && push_ok |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push lost");

endmodule

// ----- rtl/quantum_round_robin_thread_scheduler_unit.sv -----
`timescale 1ns / 1ps
// channel  dir  handshake      payload
// evt      in   valid/ready    action, thread_id, responsive
// res      out  valid/ready    running_id, idle_running, switched, accepted
// apb      in   psel/penable   quantum_reset at byte address 0
//
// one item at a time: accept, decode/table read, execute, result
// a responsive continue that cuts the running quantum adds a cut step before the result
// a reschedule adds pop, lookup and check steps per ring entry examined, plus a pop when the ring runs empty
// a tick while idle skips the execute cycle and goes straight to the reschedule
// asynchronous active-low reset; thread table valid flops clear at once, no sweep
// a new item is taken while a result waits in the output register

module quantum_round_robin_thread_scheduler_unit
#(
    parameter int MAX_THREADS  = qrrts_pkg::MAX_THREADS_DEF,
    parameter int QUANTUM_BITS = qrrts_pkg::QUANTUM_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    qrrts_evt_if.sink    evt,
    qrrts_res_if.source  res,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    qrrts_pkg::cmd_t           cmd;
    qrrts_pkg::sts_t           sts;
    logic [QUANTUM_BITS-1:0]   qreset_reg;
    logic [QUANTUM_BITS-1:0]   qreset_next;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign qreset_next = cfg_wr ? QUANTUM_BITS'(pwdata[qrrts_pkg::CFG_W-1:0]) : qreset_reg;
    assign prdata = (paddr[2] == 1'b0) ? 32'(qreset_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qreset_reg <= QUANTUM_BITS'(qrrts_pkg::QRESET_DEF);
        end
        else
        begin
            qreset_reg <= qreset_next;
        end
    end

    qrrts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (evt.valid),
        .in_ready (evt.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    qrrts_dpath
    #(
        .MAX_THREADS  (MAX_THREADS),
        .QUANTUM_BITS (QUANTUM_BITS)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .qreset       (qreset_reg),
        .action       (evt.action),
        .thread_id    (evt.thread_id),
        .responsive   (evt.responsive),
        .out_ready    (res.ready),
        .out_valid    (res.valid),
        .running_id   (res.running_id),
        .idle_running (res.idle_running),
        .switched     (res.switched),
        .accepted     (res.accepted)
    );

endmodule
